### src/julian_day_calendar_converter_assert.svh
// Assertion macros for the day number converter.
`ifndef JULIAN_DAY_CALENDAR_CONVERTER_ASSERT_SVH
`define JULIAN_DAY_CALENDAR_CONVERTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JDC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define JDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### src/jdc_pkg.sv
// Types, constants and helper functions of the day number converter.
`timescale 1ns / 1ps
package jdc_pkg;

	typedef logic signed [26:0] jd_t;
	typedef logic signed [17:0] yr_t;

	typedef enum logic [1:0] {
		KIND_NEG  = 2'd0,
		KIND_POS  = 2'd1,
		KIND_GREG = 2'd2
	} cal_kind_t;

	localparam jd_t JD_JUL_POS_START = 27'sd1721424;
	localparam jd_t JD_GREG_START    = 27'sd2299161;
	localparam jd_t JD_OFS_NEG       = 27'sd1721057;
	localparam jd_t JD_OFS_POS       = 27'sd1721423;
	localparam jd_t JD_OFS_GREG      = 27'sd1721425;
	localparam logic [32:0] JD_LAST  = 33'd16330759;
	localparam logic [33:0] GUESS_NEG  = 34'd6887153;
	localparam logic [33:0] GUESS_POS  = 34'd6885692;
	localparam logic [33:0] GUESS_GREG = 34'd688570288;
	localparam logic [33:0] DIV_JUL  = 34'd1461;
	localparam logic [33:0] DIV_GREG = 34'd146097;
	// floor(2^33 / divisor), applied to the numerator without its low ten bits
	localparam logic [22:0] RECIP_JUL  = 23'd5879489;
	localparam logic [22:0] RECIP_GREG = 23'd58796;
	localparam yr_t YEAR_MIN = -18'sd4713;
	localparam yr_t YEAR_MAX = 18'sd39999;

	typedef struct packed {
		logic             mode;
		logic             ok;
		logic             big;
		cal_kind_t        kind;
		logic             neg;
		yr_t              yy;
		logic [3:0]       mon;
		logic [4:0]       dom;
		logic [23:0]      n;
		logic [9:0]       qy;
		logic [9:0]       qc;
		logic [6:0]       ry;
		logic [1:0]       q2;
		jd_t              tpos;
		jd_t              tneg;
		jd_t              base_g;
		jd_t              base_j;
		logic             nlg;
		logic             nlj;
		logic             nl;
		logic [8:0]       mo_raw;
		jd_t              ng;
		jd_t              nj;
		jd_t              left;
		jd_t              res;
		logic signed [11:0] doy;
		logic [3:0]       mm;
	} pipe_t;

	// Signed divide by four, truncating toward zero.
	function automatic jd_t trunc4(jd_t x);
		return (x + ((x < 0) ? 27'sd3 : 27'sd0)) >>> 2;
	endfunction

	// Month table offset subtracted after the 489/16 ramp.
	function automatic jd_t month_adj(logic [3:0] m, logic nl);
		if (m > 4'd2) return nl ? 27'sd32 : 27'sd31;
		return 27'sd30;
	endfunction

	function automatic logic year_is_short(cal_kind_t k, yr_t y, logic [6:0] r, logic [1:0] q2);
		logic res;
		unique case (k)
			KIND_NEG:  res = (~y[1:0]) != 2'd0;
			KIND_POS:  res = y[1:0] != 2'd0;
			KIND_GREG: res = (y[1:0] != 2'd0) || (r == 7'd0 && q2 != 2'd0);
			default:   res = y[1:0] != 2'd0;
		endcase
		return res;
	endfunction

	// One year of correction: advance while the year end lies before the day.
	function automatic pipe_t loop_step(pipe_t p);
		pipe_t o;
		o = p;
		if (p.left < 0) begin
			o.yy = p.yy + 18'sd1;
			if (p.ry == 7'd99) begin
				o.ry = 7'd0;
				o.q2 = p.q2 + 2'd1;
			end else begin
				o.ry = p.ry + 7'd1;
			end
			o.nl = year_is_short(o.kind, o.yy, o.ry, o.q2);
			o.left = p.left + (o.nl ? 27'sd365 : 27'sd366);
		end
		return o;
	endfunction

endpackage

### src/julian_day_calendar_converter.sv
// Calendar date / Julian day number converter, both directions per item.
// Usage:
//   Drive start high with mode, year, month, day and day_number; the item is
//   taken at the rising edge where start is high and busy is low. busy is
//   high only in the first cycle after reset, so an item can enter every cycle.
//   mode 0 turns the date into day_number_out, mode 1 turns day_number into
//   year_out, month_out and day_out. valid_res low marks an out-of-range item,
//   and then every result field reads zero.
// Timing:
//   Each result shows for one cycle with done high. Throughput is one item per
//   cycle. Results pass through the three-stage year estimate (reciprocal
//   product, remainder, fix-up) and the four stages of the year correction,
//   two years a stage.
// Reset:
//   arst_n clears all pipeline valid bits and done; items in flight are dropped.
// Stall:
//   The receiver cannot hold results off; done is a one-cycle strobe.
`timescale 1ns / 1ps
`include "julian_day_calendar_converter_assert.svh"
module julian_day_calendar_converter import jdc_pkg::*; #(
	parameter int DAY_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic signed [16:0]  year,
	input  logic [3:0]          month,
	input  logic [4:0]          day,
	input  logic [DAY_BITS-1:0] day_number,
	output logic                done,
	output logic [DAY_BITS-1:0] day_number_out,
	output logic signed [16:0]  year_out,
	output logic [3:0]          month_out,
	output logic [4:0]          day_out,
	output logic                valid_res
);

	localparam logic [32:0] DAY_MAX = (33'd1 << DAY_BITS) - 33'd1;
	localparam int DV_STAGES = 3;
	localparam int LOOP_STAGES = 4;

	// ---------------- input register
	logic rdy_q, v_s1;
	logic mode_s1;
	logic signed [16:0] year_s1;
	logic [3:0] month_s1;
	logic [4:0] day_s1;
	logic [DAY_BITS-1:0] dn_s1;

	assign busy = ~rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			rdy_q <= 1'b1;
			v_s1 <= start && rdy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && rdy_q) begin
			mode_s1 <= mode;
			year_s1 <= year;
			month_s1 <= month;
			day_s1 <= day;
			dn_s1 <= day_number;
		end
	end

	// ---------------- range checks and year estimate numerator
	logic v_s2;
	pipe_t p_s2;
	logic [33:0] num_s2;
	pipe_t p2;
	logic [33:0] num2;
	logic [32:0] dn33;
	logic [33:0] n34;

	always_comb begin
		dn33 = {{(33-DAY_BITS){1'b0}}, dn_s1};
		n34 = {10'd0, dn33[23:0]};
		p2 = '0;
		p2.mode = mode_s1;
		p2.yy = {year_s1[16], year_s1};
		p2.mon = month_s1;
		p2.dom = day_s1;
		p2.n = dn33[23:0];
		p2.big = dn33 > JD_LAST;
		p2.ok = (year_s1 != 17'sd0) && (p2.yy >= YEAR_MIN) && (p2.yy <= YEAR_MAX) &&
			(month_s1 >= 4'd1) && (month_s1 <= 4'd12) && (day_s1 >= 5'd1);
		if ($signed({3'd0, dn33[23:0]}) < JD_JUL_POS_START) begin
			p2.kind = KIND_NEG;
			p2.neg = 1'b1;
			num2 = GUESS_NEG - (n34 << 2);
		end else if ($signed({3'd0, dn33[23:0]}) < JD_GREG_START) begin
			p2.kind = KIND_POS;
			num2 = (n34 << 2) - GUESS_POS;
		end else begin
			p2.kind = KIND_GREG;
			num2 = n34 * 34'd400 - GUESS_GREG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		p_s2 <= p2;
		num_s2 <= num2;
	end

	// ---------------- year estimate: reciprocal product, remainder, fix-up
	logic dv_v_s3 [1:DV_STAGES];
	pipe_t dv_p_s3 [1:DV_STAGES];
	logic [33:0] dv_num_s3 [1:2];
	logic [15:0] dv_q_s3 [1:DV_STAGES];
	logic [22:0] dv_recip;
	logic [45:0] dv_prod;
	logic [33:0] dv_div2, dv_div3;

	always_comb begin
		dv_recip = (p_s2.kind == KIND_GREG) ? RECIP_GREG : RECIP_JUL;
		dv_prod = 46'(num_s2[32:10]) * 46'(dv_recip);
		dv_div2 = (dv_p_s3[1].kind == KIND_GREG) ? DIV_GREG : DIV_JUL;
		dv_div3 = (dv_p_s3[2].kind == KIND_GREG) ? DIV_GREG : DIV_JUL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s3[1] <= 1'b0;
			dv_v_s3[2] <= 1'b0;
			dv_v_s3[3] <= 1'b0;
		end else begin
			dv_v_s3[1] <= v_s2;
			dv_v_s3[2] <= dv_v_s3[1];
			dv_v_s3[3] <= dv_v_s3[2];
		end
	end

	always_ff @(posedge clk) begin
		// the estimate falls at most two short of the true quotient
		dv_p_s3[1] <= p_s2;
		dv_num_s3[1] <= num_s2;
		dv_q_s3[1] <= dv_prod[38:23];
		dv_p_s3[2] <= dv_p_s3[1];
		dv_num_s3[2] <= dv_num_s3[1] - 34'(dv_q_s3[1]) * dv_div2;
		dv_q_s3[2] <= dv_q_s3[1];
		dv_p_s3[3] <= dv_p_s3[2];
		if (dv_num_s3[2] >= (dv_div3 << 1)) dv_q_s3[3] <= dv_q_s3[2] + 16'd2;
		else if (dv_num_s3[2] >= dv_div3) dv_q_s3[3] <= dv_q_s3[2] + 16'd1;
		else dv_q_s3[3] <= dv_q_s3[2];
	end

	// ---------------- year pick, century quotients, 1461 products
	logic v_s4;
	pipe_t p_s4;
	pipe_t p4;
	yr_t gq, guess;
	logic [15:0] y16, ym16;

	always_comb begin
		p4 = dv_p_s3[DV_STAGES];
		gq = {2'b00, dv_q_s3[DV_STAGES]};
		guess = p4.neg ? -gq : gq;
		if (p4.kind == KIND_POS && guess < 18'sd1) guess = 18'sd1;
		if (p4.mode) begin
			p4.yy = guess;
			p4.mon = 4'd12;
			p4.dom = 5'd31;
		end else begin
			p4.kind = (p4.yy < 0) ? KIND_NEG : KIND_POS;
		end
		y16 = p4.yy[15:0];
		ym16 = y16 - 16'd1;
		p4.qy = 10'((29'(y16) * 29'd5243) >> 19);
		p4.qc = 10'((29'(ym16) * 29'd5243) >> 19);
		p4.tpos = (jd_t'(p4.yy) - 27'sd1) * 27'sd1461;
		p4.tneg = (jd_t'(p4.yy) + 27'sd1) * 27'sd1461;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= dv_v_s3[DV_STAGES];
	end

	always_ff @(posedge clk) p_s4 <= p4;

	// ---------------- year bases, leap flags, month ramp
	logic v_s5;
	pipe_t p_s5;
	pipe_t p5;

	always_comb begin
		p5 = p_s4;
		p5.tpos = trunc4(p_s4.tpos);
		p5.tneg = trunc4(p_s4.tneg);
		p5.ry = 7'(p_s4.yy[15:0] - 16'(p_s4.qy) * 16'd100);
		p5.q2 = p_s4.qy[1:0];
		p5.base_g = p5.tpos + $signed({17'd0, p_s4.qc >> 2}) - $signed({17'd0, p_s4.qc})
			+ JD_OFS_GREG;
		p5.base_j = (p_s4.kind == KIND_NEG) ? p5.tneg + JD_OFS_NEG : p5.tpos + JD_OFS_POS;
		p5.nlg = year_is_short(KIND_GREG, p_s4.yy, p5.ry, p5.q2);
		p5.nlj = year_is_short(p_s4.kind, p_s4.yy, p5.ry, p5.q2);
		p5.mo_raw = 9'((13'(p_s4.mon) * 13'd489) >> 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) p_s5 <= p5;

	// ---------------- day numbers in both calendars
	logic v_s6;
	pipe_t p_s6;
	pipe_t p6;
	jd_t mo_j, dom_j;

	always_comb begin
		p6 = p_s5;
		mo_j = $signed({18'd0, p_s5.mo_raw});
		dom_j = $signed({22'd0, p_s5.dom});
		p6.ng = p_s5.base_g + mo_j - month_adj(p_s5.mon, p_s5.nlg) + dom_j;
		p6.nj = p_s5.base_j + mo_j - month_adj(p_s5.mon, p_s5.nlj) + dom_j;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end

	always_ff @(posedge clk) p_s6 <= p6;

	// ---------------- calendar pick; date result or year-end distance
	logic v_s7;
	pipe_t p_s7;
	pipe_t p7;
	logic use_g;

	always_comb begin
		p7 = p_s6;
		if (p_s6.mode) begin
			use_g = p_s6.kind == KIND_GREG;
			p7.left = (use_g ? p_s6.ng : p_s6.nj) - $signed({3'd0, p_s6.n});
			p7.nl = use_g ? p_s6.nlg : p_s6.nlj;
			p7.res = '0;
		end else begin
			use_g = (p_s6.yy >= 18'sd1) && (p_s6.ng >= JD_GREG_START);
			p7.res = use_g ? p_s6.ng : p_s6.nj;
			p7.ok = p_s6.ok && (p7.res >= 0) && ({6'd0, p7.res} <= DAY_MAX);
			p7.left = '0;
			p7.nl = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end

	always_ff @(posedge clk) p_s7 <= p7;

	// ---------------- year correction, two years per stage
	logic lp_v_s8 [0:LOOP_STAGES];
	pipe_t lp_p_s8 [0:LOOP_STAGES];

	assign lp_v_s8[0] = v_s7;
	assign lp_p_s8[0] = p_s7;

	for (genvar j = 0; j < LOOP_STAGES; j++) begin : g_loop
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lp_v_s8[j+1] <= 1'b0;
			else lp_v_s8[j+1] <= lp_v_s8[j];
		end

		always_ff @(posedge clk) lp_p_s8[j+1] <= loop_step(loop_step(lp_p_s8[j]));
	end

	// ---------------- day of year and month estimate
	logic v_s9;
	pipe_t p_s9;
	pipe_t p9;
	jd_t doy_j;
	logic [12:0] xm;

	always_comb begin
		p9 = lp_p_s8[LOOP_STAGES];
		doy_j = (p9.nl ? 27'sd365 : 27'sd366) - p9.left;
		p9.doy = doy_j[11:0];
		xm = 13'((doy_j + (p9.nl ? 27'sd32 : 27'sd31)) << 4);
		p9.mm = 4'((26'(xm) * 26'd4289) >> 21);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else v_s9 <= lp_v_s8[LOOP_STAGES];
	end

	always_ff @(posedge clk) p_s9 <= p9;

	// ---------------- day of month, late-January fix, output register
	logic done_q, valid_q;
	logic [DAY_BITS-1:0] dn_out_q;
	logic signed [16:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [8:0] mo2;
	logic signed [11:0] dd;
	logic [3:0] mm_f;
	logic ok1;
	logic [32:0] res33;
	logic fields_zero, date_ok;

	always_comb begin
		mo2 = 9'((13'(p_s9.mm) * 13'd489) >> 4);
		dd = p_s9.doy - ($signed({3'd0, mo2}) - 12'(month_adj(p_s9.mm, p_s9.nl)));
		mm_f = p_s9.mm;
		if (dd < 12'sd1) begin
			mm_f = 4'd1;
			dd = dd + 12'sd31;
		end
		ok1 = !p_s9.big && (p_s9.yy <= YEAR_MAX) && (p_s9.yy >= YEAR_MIN) &&
			(p_s9.yy != 18'sd0);
		res33 = {6'd0, p_s9.res};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= v_s9;
	end

	always_ff @(posedge clk) begin
		dn_out_q <= '0;
		year_q <= '0;
		month_q <= '0;
		day_q <= '0;
		valid_q <= 1'b0;
		if (p_s9.mode) begin
			if (ok1) begin
				year_q <= p_s9.yy[16:0];
				month_q <= mm_f;
				day_q <= dd[4:0];
				valid_q <= 1'b1;
			end
		end else if (p_s9.ok) begin
			dn_out_q <= res33[DAY_BITS-1:0];
			valid_q <= 1'b1;
		end
	end

	assign done = done_q;
	assign day_number_out = dn_out_q;
	assign year_out = year_q;
	assign month_out = month_q;
	assign day_out = day_q;
	assign valid_res = valid_q;

	assign fields_zero = day_number_out == '0 && year_out == '0 && month_out == 4'd0 &&
		day_out == 5'd0;
	assign date_ok = month_out <= 4'd12 && day_out != 5'd0 && day_number_out == '0;

	`JDC_ASSERT_NEXT(a_accept_enters, start && !busy, v_s1)
	`JDC_ASSERT_NOW(a_invalid_zero, done && !valid_res, fields_zero)
	`JDC_ASSERT_NOW(a_date_shape, done && valid_res && month_out != 4'd0, date_ok)

endmodule

### sim/tb.sv
// Testbench for the calendar date / Julian day number converter.
`timescale 1ns / 1ps
module tb;
	import jdc_pkg::*;

	typedef struct {
		logic [23:0]        dn;
		logic signed [16:0] yr;
		logic [3:0]         mon;
		logic [4:0]         dom;
		logic               ok;
	} conv_res_t;

	localparam int CAL_NEG  = 0;
	localparam int CAL_POS  = 1;
	localparam int CAL_GREG = 2;
	localparam logic MODE_TO_DAY  = 1'b0;
	localparam logic MODE_TO_DATE = 1'b1;

	int fail_count = 0;

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic bit short_year(int kind, longint y);
		if (kind == CAL_NEG) return ((3 - y) & 3) != 0;
		if (kind == CAL_POS) return (y & 3) != 0;
		return (y & 3) != 0 || ((y % 100) == 0 && ((y / 100) & 3) != 0);
	endfunction

	function automatic longint month_start(longint m, bit nl);
		return (m * 489) / 16 - ((m > 2) ? (nl ? 32 : 31) : 30);
	endfunction

	function automatic longint day_of(int kind, longint y, longint m, longint d);
		longint off, c;
		off = month_start(m, short_year(kind, y));
		if (kind == CAL_NEG) return (1461 * (y + 1)) / 4 + off + d + 1721057;
		if (kind == CAL_POS) return (1461 * (y - 1)) / 4 + off + d + 1721423;
		c = (y - 1) / 100;
		return (1461 * (y - 1)) / 4 + c / 4 - c + off + d + 1721425;
	endfunction

	function automatic conv_res_t convert(logic md, logic signed [16:0] yin, logic [3:0] m,
			logic [4:0] d, logic [23:0] dnin);
		conv_res_t r;
		longint y, n, yy, left, doy, mm, dd;
		int kind, step;
		bit nl;
		r = '{default: '0};
		if (md == MODE_TO_DAY) begin
			y = yin;
			if (y == 0 || y < -4713 || y > 39999 || m < 1 || m > 12 || d < 1) return r;
			n = day_of(CAL_GREG, y, m, d);
			if (n < 2299161) n = day_of(y < 0 ? CAL_NEG : CAL_POS, y, m, d);
			if (n < 0 || n > 24'hFFFFFF) return r;
			r.dn = n[23:0];
			r.ok = 1'b1;
		end else begin
			n = dnin;
			kind = (n < 1721424) ? CAL_NEG : (n < 2299161) ? CAL_POS : CAL_GREG;
			if (kind == CAL_NEG) yy = (4 * n - 6887153) / 1461;
			else if (kind == CAL_POS) begin
				yy = (4 * n - 6885692) / 1461;
				if (yy < 1) yy = 1;
			end else yy = (400 * n - 688570288) / 146097;
			nl = short_year(kind, yy);
			left = day_of(kind, yy, 12, 31) - n;
			for (step = 0; step < 8 && left < 0; step++) begin
				yy++;
				nl = short_year(kind, yy);
				left += nl ? 365 : 366;
			end
			doy = (nl ? 365 : 366) - left;
			mm = (16 * (doy + (nl ? 32 : 31))) / 489;
			dd = doy - month_start(mm, nl);
			if (dd < 1) begin
				mm = 1;
				dd += 31;
			end
			if (yy > 39999 || yy < -4713 || yy == 0) return r;
			r.yr = yy[16:0];
			r.mon = mm[3:0];
			r.dom = dd[4:0];
			r.ok = 1'b1;
		end
		return r;
	endfunction

	class conv_board;
		conv_res_t pending[$];
		function void note_item(logic md, logic signed [16:0] y, logic [3:0] m,
				logic [4:0] d, logic [23:0] n);
			pending.push_back(convert(md, y, m, d, n));
		endfunction
		task check_result(conv_res_t got);
			conv_res_t want;
			if (pending.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.dn !== want.dn)
				report($sformatf("day_number_out %0d, want %0d", got.dn, want.dn));
			if (got.yr !== want.yr)
				report($sformatf("year_out %0d, want %0d", got.yr, want.yr));
			if (got.mon !== want.mon)
				report($sformatf("month_out %0d, want %0d", got.mon, want.mon));
			if (got.dom !== want.dom)
				report($sformatf("day_out %0d, want %0d", got.dom, want.dom));
			if (got.ok !== want.ok)
				report($sformatf("valid_res %0b, want %0b", got.ok, want.ok));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic mode = 1'b0;
	logic signed [16:0] year = '0;
	logic [3:0] month = '0;
	logic [4:0] day = '0;
	logic [23:0] day_number = '0;
	logic [23:0] day_number_out;
	logic signed [16:0] year_out;
	logic [3:0] month_out;
	logic [4:0] day_out;
	logic valid_res;

	conv_board board = new();
	int idle_pct = 0;

	always #5 clk = ~clk;

	julian_day_calendar_converter dut (.*);

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result('{day_number_out, year_out, month_out, day_out, valid_res});
		if (arst_n && start && !busy)
			board.note_item(mode, year, month, day, day_number);
	end

	// Present one item and hold it until taken; idle gaps go in front.
	task automatic send(logic md, logic signed [16:0] y, logic [3:0] m, logic [4:0] d,
			logic [23:0] n);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		mode <= md;
		year <= y;
		month <= m;
		day <= d;
		day_number <= n;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	task automatic send_random();
		int r;
		logic signed [16:0] y;
		r = $urandom_range(99);
		if (r < 40) begin
			y = 17'($urandom_range(1, 2 * 4713) - 4713);
			if ($urandom_range(3) == 0) y = 17'($urandom_range(1500, 1700));
			else if ($urandom_range(3) == 0) y = 17'($urandom_range(1, 39999));
			send(MODE_TO_DAY, y, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
				24'($urandom));
		end else if (r < 80) begin
			send(MODE_TO_DATE, 17'($urandom), 4'($urandom), 5'($urandom),
				24'(($urandom_range(1) != 0) ? $urandom_range(0, 16331000)
					: $urandom_range(1720000, 2400000)));
		end else begin
			send(1'($urandom_range(1)), 17'($urandom), 4'($urandom), 5'($urandom),
				24'($urandom));
		end
	endtask

	initial begin
		int ph, i;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send(MODE_TO_DAY, -4713, 1, 1, 0);
		send(MODE_TO_DAY, -1, 12, 31, 0);
		send(MODE_TO_DAY, 1, 1, 1, 0);
		send(MODE_TO_DAY, 0, 6, 6, 0);
		send(MODE_TO_DAY, -4714, 1, 1, 0);
		send(MODE_TO_DAY, 40000, 1, 1, 0);
		send(MODE_TO_DAY, 39999, 12, 31, 0);
		send(MODE_TO_DAY, 1582, 10, 4, 0);
		send(MODE_TO_DAY, 1582, 10, 10, 0);
		send(MODE_TO_DAY, 1582, 10, 15, 0);
		send(MODE_TO_DAY, 2000, 2, 29, 0);
		send(MODE_TO_DAY, 1900, 2, 31, 0);
		send(MODE_TO_DAY, 2024, 0, 5, 0);
		send(MODE_TO_DAY, 2024, 15, 0, 24'hFFFFFF);
		send(MODE_TO_DAY, -65536, 1, 31, 0);
		send(MODE_TO_DATE, 0, 0, 0, 0);
		send(MODE_TO_DATE, 0, 0, 0, 1721423);
		send(MODE_TO_DATE, 0, 0, 0, 1721424);
		send(MODE_TO_DATE, 0, 0, 0, 2299160);
		send(MODE_TO_DATE, 0, 0, 0, 2299161);
		send(MODE_TO_DATE, 0, 0, 0, 2451545);
		send(MODE_TO_DATE, 0, 0, 0, 16330759);
		send(MODE_TO_DATE, 0, 0, 0, 16330760);
		send(MODE_TO_DATE, 17'h1FFFF, 15, 31, 24'hFFFFFF);
		// Wait for every result before the next item.
		drain();
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 64 : (ph == 2) ? 24 : 0;
			for (i = 0; i < 210; i++) send_random();
		end
		drain();
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

### sim.f
+incdir+src
src/jdc_pkg.sv
src/julian_day_calendar_converter.sv
sim/tb.sv
